### rtl/core/pwgs_pkg.sv
// Shared constants, payload types and cell types for the primer window search.
`timescale 1ns / 1ps
`default_nettype none

package pwgs_pkg;

  localparam int WINDOW_DEPTH  = 32;
  localparam int MAX_MOTIF_LEN = 65536;
  localparam int START_MARGIN  = 11;

  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W   = $clog2(WINDOW_DEPTH);
  localparam int AVAIL_W = FILL_W;
  localparam int POS_W   = $clog2(MAX_MOTIF_LEN + 1);

  localparam int CFG_DATA_W = 8;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_GOAL_SCORE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCORE_SLOP = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_LENGTH = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH = 2'd3;

  localparam logic [7:0] RESET_GOAL_SCORE = 8'd60;
  localparam logic [3:0] RESET_SCORE_SLOP = 4'd2;
  localparam logic [4:0] RESET_MIN_LENGTH = 5'd20;
  localparam logic [4:0] RESET_MAX_LENGTH = 5'd30;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  typedef struct packed {
    logic [2:0] base;
    logic       last_base;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] start_pos;
    logic [4:0]  window_length;
    logic [7:0]  window_score;
    logic        end_of_motif;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [7:0] goal_score;
    logic [3:0] score_slop;
    logic [4:0] min_length;
    logic [4:0] max_length;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_FOUND = 4'b0100,
    ST_NONE  = 4'b1000
  } cell_status_t;

  typedef struct packed {
    cell_status_t       status;
    logic [7:0]         score;
    logic [4:0]         len;
    logic [AVAIL_W-1:0] avail;
  } cell_t;

  typedef struct packed {
    logic       apply;
    logic       finalize;
    logic       shift;
    logic [2:0] base;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/core/pwgs_cell.sv
// One start cell: grows the window of its start position base by base.
`timescale 1ns / 1ps
`default_nettype none

module pwgs_cell (
  input  wire                       clk,
  input  wire pwgs_pkg::cell_cmd_t  cmd,
  input  wire pwgs_pkg::cfg_t       cfg,
  input  wire                       load,
  input  wire pwgs_pkg::cell_t      nbr,
  output pwgs_pkg::cell_t           entry
);
  import pwgs_pkg::*;

  cell_t        cur;
  cell_t        stepped;
  cell_t        finalized;
  cell_t        entry_next;
  logic [2:0]   w;
  logic [5:0]   len1;
  logic [8:0]   sc1;
  logic [9:0]   lo_sum;
  logic [8:0]   hi_lim;
  logic         run_base;
  cell_status_t run_status;

  always_comb begin
    cur = entry;
    if (load) begin
      cur.status = ST_RUN;
      cur.score  = '0;
      cur.len    = '0;
      cur.avail  = '0;
    end

    case (cmd.base)
      BASE_A, BASE_T: w = 3'd2;
      BASE_C, BASE_G: w = 3'd4;
      default:        w = 3'd0;
    endcase

    len1   = {1'b0, cur.len} + 6'd1;
    sc1    = {1'b0, cur.score} + {6'b0, w};
    lo_sum = {1'b0, sc1} + {6'b0, cfg.score_slop};
    hi_lim = {1'b0, cfg.goal_score} + {5'b0, cfg.score_slop};

    // Wallace window growth for one consumed base
    if (w == 3'd0) begin
      run_status = ST_NONE;
    end else if (lo_sum < {2'b0, cfg.goal_score}) begin
      run_status = (len1 > {1'b0, cfg.max_length}) ? ST_NONE : ST_RUN;
    end else if (sc1 > hi_lim) begin
      run_status = ST_NONE;
    end else if (len1 > {1'b0, cfg.max_length}) begin
      run_status = ST_NONE;
    end else if ((lo_sum == {2'b0, cfg.goal_score}) &&
                 (len1 != {1'b0, cfg.max_length})) begin
      run_status = ST_LOOK;
    end else if (len1 < {1'b0, cfg.min_length}) begin
      run_status = ST_RUN;
    end else begin
      run_status = ST_FOUND;
    end

    // At the low edge, an A/T or a short window takes the next base in
    case (cur.status)
      ST_RUN:  run_base = 1'b1;
      ST_LOOK: run_base = (w == 3'd2) || (cur.len < cfg.min_length);
      default: run_base = 1'b0;
    endcase

    stepped = cur;
    if (cur.avail < AVAIL_W'(WINDOW_DEPTH)) begin
      stepped.avail = cur.avail + AVAIL_W'(1);
    end
    if (run_base) begin
      stepped.status = run_status;
      stepped.score  = sc1[7:0];
      stepped.len    = len1[4:0];
    end else if (cur.status == ST_LOOK) begin
      stepped.status = ST_FOUND;
    end

    // Motif end: resolve anything still open
    finalized = entry;
    case (entry.status)
      ST_RUN:  finalized.status = ST_NONE;
      ST_LOOK: finalized.status = (entry.len >= cfg.min_length) ? ST_FOUND : ST_NONE;
      default: finalized.status = entry.status;
    endcase

    if (cmd.apply) begin
      entry_next = stepped;
    end else if (cmd.finalize) begin
      entry_next = finalized;
    end else if (cmd.shift) begin
      entry_next = nbr;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

### rtl/core/primer_window_gc_score_search.sv
// Wallace-rule primer window search over a streamed motif, built as a chain of start cells.
// Flow: a base is applied in its transfer cycle; the drain state then retires starts from the
//   head; the final base first passes a finalize state that resolves open windows.
// No new base is taken until the drain ends (up to WINDOW_DEPTH starts at the final base);
//   the drain pops the head of the cell chain one start per cycle while the output is free.
// Reset: synchronous active-high rst clears the control state and the output valid flag and
//   loads the configuration defaults; cell contents are qualified by the fill count.
`timescale 1ns / 1ps
`default_nettype none

module primer_window_gc_score_search (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire pwgs_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output pwgs_pkg::out_item_t                   out_data,
  input  wire                                   cfg_write,
  input  wire [pwgs_pkg::REG_IDX_W-1:0]         cfg_index,
  input  wire [pwgs_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pwgs_pkg::*;

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_FINAL = 3'b010,
    CS_DRAIN = 3'b100
  } ctrl_state_t;

  ctrl_state_t       state, state_next;
  cfg_t              cfg;
  logic [FILL_W-1:0] fill, fill_next;
  logic [POS_W-1:0]  position, position_next;
  logic              overflow_seen, overflow_seen_next;
  logic              last_mode, last_mode_next;
  logic              emitted_any, emitted_any_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  cell_t             cells [WINDOW_DEPTH];
  cell_t             nbr   [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] load_vec;
  cell_cmd_t         cmd;

  logic              accept;
  logic              store;
  logic              pop;
  logic              out_free;
  logic              head_valid;
  logic              head_none;
  logic              head_marg;
  logic              head_deep;
  logic              reportable;
  logic              later_found;
  logic [POS_W-1:0]  start_full;

  // Accept a base only when idle; hold the input side stalled during reset.
  assign in_stall = rst || (state != CS_IDLE);
  assign accept   = in_valid && !in_stall;
  // Store the base only below the position limit; past it, just flag overflow.
  assign store    = position < POS_W'(MAX_MOTIF_LEN);
  assign out_free = !out_valid || !out_stall;

  assign cmd.apply    = accept && store;
  assign cmd.finalize = (state == CS_FINAL);
  assign cmd.shift    = pop;
  assign cmd.base     = in_data.base;

  // Chain of start cells; cell 0 holds the oldest pending start.
  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    assign load_vec[g] = cmd.apply && (fill[IDX_W-1:0] == IDX_W'(g));
    if (g == WINDOW_DEPTH - 1) begin : g_tail
      assign nbr[g] = '0;
    end else begin : g_link
      assign nbr[g] = cells[g+1];
    end
    pwgs_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .cfg   (cfg),
      .load  (load_vec[g]),
      .nbr   (nbr[g]),
      .entry (cells[g])
    );
  end

  // Head cell decision
  assign head_valid = (fill != '0);
  assign head_none  = (cells[0].status == ST_NONE);
  assign head_marg  = (cells[0].avail >= AVAIL_W'(START_MARGIN));
  assign head_deep  = (cells[0].avail >= AVAIL_W'(WINDOW_DEPTH));
  assign reportable = (cells[0].status == ST_FOUND) && head_marg;
  assign start_full = position - POS_W'(fill);

  // Tell whether a later start will still report, so the end mark lands on the last result.
  always_comb begin
    later_found = 1'b0;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      later_found = later_found ||
                    ((FILL_W'(i) < fill) && (cells[i].status == ST_FOUND) &&
                     (cells[i].avail >= AVAIL_W'(START_MARGIN)));
    end
  end

  always_comb begin
    state_next         = state;
    fill_next          = fill;
    position_next      = position;
    overflow_seen_next = overflow_seen;
    last_mode_next     = last_mode;
    emitted_any_next   = emitted_any;
    pop                = 1'b0;
    // drop the output once its transfer completes
    out_valid_next     = out_valid && out_stall;
    out_data_next      = out_data;

    case (state)
      CS_IDLE: begin
        if (accept) begin
          if (store) begin
            position_next = position + POS_W'(1);
            fill_next     = fill + FILL_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          last_mode_next   = in_data.last_base;
          emitted_any_next = 1'b0;
          state_next       = in_data.last_base ? CS_FINAL : CS_DRAIN;
        end
      end

      CS_FINAL: begin
        state_next = CS_DRAIN;
      end

      CS_DRAIN: begin
        if (head_valid) begin
          if (reportable) begin
            // hold the head until the output register frees up
            if (out_free) begin
              pop                         = 1'b1;
              out_valid_next              = 1'b1;
              out_data_next.found         = 1'b1;
              out_data_next.start_pos     = 16'(start_full);
              out_data_next.window_length = cells[0].len;
              out_data_next.window_score  = cells[0].score;
              out_data_next.end_of_motif  = last_mode && !later_found;
              out_data_next.overflow      = overflow_seen;
              emitted_any_next            = 1'b1;
            end
          end else if (last_mode || head_none || head_deep) begin
            // drop a start with no window, a too-near start at the end, or a stale one
            pop = 1'b1;
          end else begin
            state_next = CS_IDLE;
          end
          if (pop) begin
            fill_next = fill - FILL_W'(1);
          end
        end else if (!last_mode) begin
          state_next = CS_IDLE;
        end else if (emitted_any || out_free) begin
          if (!emitted_any) begin
            // end mark alone when the motif gave no window
            out_valid_next             = 1'b1;
            out_data_next              = '0;
            out_data_next.end_of_motif = 1'b1;
            out_data_next.overflow     = overflow_seen;
          end
          position_next      = '0;
          overflow_seen_next = 1'b0;
          last_mode_next     = 1'b0;
          state_next         = CS_IDLE;
        end
      end

      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= CS_IDLE;
      fill           <= '0;
      position       <= '0;
      overflow_seen  <= 1'b0;
      last_mode      <= 1'b0;
      emitted_any    <= 1'b0;
      out_valid      <= 1'b0;
      cfg.goal_score <= RESET_GOAL_SCORE;
      cfg.score_slop <= RESET_SCORE_SLOP;
      cfg.min_length <= RESET_MIN_LENGTH;
      cfg.max_length <= RESET_MAX_LENGTH;
    end else begin
      state         <= state_next;
      fill          <= fill_next;
      position      <= position_next;
      overflow_seen <= overflow_seen_next;
      last_mode     <= last_mode_next;
      emitted_any   <= emitted_any_next;
      out_valid     <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_GOAL_SCORE: cfg.goal_score <= cfg_data[7:0];
          REG_SCORE_SLOP: cfg.score_slop <= cfg_data[3:0];
          REG_MIN_LENGTH: cfg.min_length <= cfg_data[4:0];
          REG_MAX_LENGTH: cfg.max_length <= cfg_data[4:0];
          default:        ;
        endcase
      end
    end
  end

  // Output payload carries no reset
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

`default_nettype wire

### rtl/core/pwgs_checker.sv
// Port-level checks for the primer window search, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pwgs_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire pwgs_pkg::out_item_t out_data
);
  import pwgs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |->
      out_data.end_of_motif && (out_data.start_pos == 16'd0) &&
      (out_data.window_length == 5'd0) && (out_data.window_score == 8'd0))
    else $error("empty result is not a clean end mark");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |->
      (out_data.window_length != 5'd0) &&
      (out_data.window_score >= {2'b0, out_data.window_length, 1'b0}) &&
      (out_data.window_score <= {1'b0, out_data.window_length, 2'b0}))
    else $error("window score outside two to four per base");

endmodule

bind primer_window_gc_score_search pwgs_checker u_pwgs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
